// ----- design/diagnostic_command_parser_assert.svh -----
// Assertion macros for the diagnostic command parser.
`ifndef DIAGNOSTIC_COMMAND_PARSER_ASSERT_SVH
`define DIAGNOSTIC_COMMAND_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define DCP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("diagnostic command parser: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("diagnostic command parser: next-cycle check failed");

`else

`define DCP_ASSERT_SAME(lbl, ante, cons)
`define DCP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/dcp_pkg.sv -----
// Shared types, codes and constants of the diagnostic command parser.
package dcp_pkg;

    localparam int KEY_W   = 8;
    localparam int NOTE_W  = 7;
    localparam int OP_W    = 2;
    localparam int MODE_W  = 3;
    localparam int SEL_W   = 16;
    localparam int SWEEP_W = 17;
    localparam int DIGIT_W = 4;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 104;

    localparam int SWEEP_STRIDE_DEF = 20;
    localparam logic [SEL_W-1:0] LEDS_RESET = 16'd300;
    localparam logic [SEL_W-1:0] SEL_NONE   = 16'hFFFF;
    localparam logic [SEL_W-1:0] ENTRY_MAX  = 16'd65534;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_KEY      = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

    // parser modes
    localparam logic [MODE_W-1:0] MODE_INTRO    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LED      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STRIP    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PHI      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_THETA    = 3'd6;

    // character codes
    localparam logic [KEY_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [KEY_W-1:0] CH_NINE  = 8'h39;
    localparam logic [KEY_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [KEY_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [KEY_W-1:0] CH_CASE  = 8'h20;
    localparam logic [KEY_W-1:0] CH_L     = 8'h4C;
    localparam logic [KEY_W-1:0] CH_T     = 8'h54;
    localparam logic [KEY_W-1:0] CH_S     = 8'h53;
    localparam logic [KEY_W-1:0] CH_H     = 8'h48;
    localparam logic [KEY_W-1:0] CH_V     = 8'h56;
    localparam logic [KEY_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [KEY_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [KEY_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [KEY_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [KEY_W-1:0] CH_COLON = 8'h3A;
    localparam logic [KEY_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [KEY_W-1:0] CH_CR    = 8'h0D;
    localparam logic [KEY_W-1:0] CH_LF    = 8'h0A;

    // classified request passed from front to back
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic               is_letter;
        logic [MODE_W-1:0]  letter_mode;
        logic               is_inc;
        logic               is_dec;
        logic               is_colon;
        logic               is_eol;
        logic [NOTE_W-1:0]  note;
    } cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

// ----- design/dcp_front.sv -----
// Front end: accepts requests and classifies key characters.
module dcp_front
(
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [dcp_pkg::OP_W-1:0]       s_tuser,
    input  dcp_pkg::q_status_t             q_stat,
    output logic                           push,
    output dcp_pkg::cmd_t                  push_cmd
);

    logic [dcp_pkg::KEY_W-1:0] key;
    logic [dcp_pkg::KEY_W-1:0] upper;
    logic [dcp_pkg::KEY_W-1:0] digit_full;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    assign key        = s_tdata[dcp_pkg::KEY_W-1:0];
    assign digit_full = key - dcp_pkg::CH_ZERO;

    always_comb
    begin
        // fold lower case letters onto upper case
        if (key >= dcp_pkg::CH_LOW_A && key <= dcp_pkg::CH_LOW_Z)
        begin
            upper = key - dcp_pkg::CH_CASE;
        end
        else
        begin
            upper = key;
        end

        push_cmd.op          = s_tuser;
        push_cmd.note        = s_tdata[dcp_pkg::KEY_W +: dcp_pkg::NOTE_W];
        push_cmd.is_digit    = (key >= dcp_pkg::CH_ZERO) && (key <= dcp_pkg::CH_NINE);
        push_cmd.digit       = digit_full[dcp_pkg::DIGIT_W-1:0];
        push_cmd.is_inc      = (key == dcp_pkg::CH_PLUS) || (key == dcp_pkg::CH_EQ);
        push_cmd.is_dec      = (key == dcp_pkg::CH_MINUS) || (key == dcp_pkg::CH_UNDER);
        push_cmd.is_colon    = (key == dcp_pkg::CH_COLON) || (key == dcp_pkg::CH_SEMI);
        push_cmd.is_eol      = (key == dcp_pkg::CH_CR) || (key == dcp_pkg::CH_LF);
        push_cmd.is_letter   = 1'b1;
        push_cmd.letter_mode = dcp_pkg::MODE_WAIT;
        unique case (upper)
            dcp_pkg::CH_L: push_cmd.letter_mode = dcp_pkg::MODE_LED;
            dcp_pkg::CH_T: push_cmd.letter_mode = dcp_pkg::MODE_TRIANGLE;
            dcp_pkg::CH_S: push_cmd.letter_mode = dcp_pkg::MODE_STRIP;
            dcp_pkg::CH_H: push_cmd.letter_mode = dcp_pkg::MODE_PHI;
            dcp_pkg::CH_V: push_cmd.letter_mode = dcp_pkg::MODE_THETA;
            default:       push_cmd.is_letter   = 1'b0;
        endcase
    end

endmodule

// ----- design/dcp_queue.sv -----
// Short request queue between front end and back end.
module dcp_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dcp_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output dcp_pkg::cmd_t      pop_cmd,
    output dcp_pkg::q_status_t q_stat
);

    dcp_pkg::cmd_t entry_reg [dcp_pkg::QDEPTH];

    logic [dcp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [dcp_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [dcp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [dcp_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [dcp_pkg::QCNT_W-1:0] count_reg;
    logic [dcp_pkg::QCNT_W-1:0] count_next;

    assign q_stat.count = count_reg;
    assign q_stat.full  = (count_reg == dcp_pkg::QCNT_W'(dcp_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dcp_pkg::QPTR_W'(dcp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dcp_pkg::QPTR_W'(dcp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/dcp_back.sv -----
// Back end: parser state, selections and the registered result.
module dcp_back
#(
    parameter int SWEEP_STRIDE = dcp_pkg::SWEEP_STRIDE_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dcp_pkg::SEL_W-1:0]       cfg_wdata,
    input  logic                            cmd_valid,
    input  dcp_pkg::cmd_t                   cmd,
    output logic                            cmd_take,
    output logic [dcp_pkg::MODE_W-1:0]      mode,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dcp_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int RES_W = 1 + dcp_pkg::MODE_W + 6 * dcp_pkg::SEL_W;
    localparam int PROD_W = dcp_pkg::SEL_W + 4;

    logic [dcp_pkg::SEL_W-1:0]   leds_reg;
    logic [dcp_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [dcp_pkg::SEL_W-1:0]   entry_reg, entry_next;
    logic [dcp_pkg::SWEEP_W-1:0] sweep_reg, sweep_next;
    logic [dcp_pkg::SEL_W-1:0]   led_reg, led_next;
    logic [dcp_pkg::SEL_W-1:0]   led_strip_reg, led_strip_next;
    logic [dcp_pkg::SEL_W-1:0]   tri_reg, tri_next;
    logic [dcp_pkg::SEL_W-1:0]   strip_reg, strip_next;
    logic [dcp_pkg::SEL_W-1:0]   phi_reg, phi_next;
    logic [dcp_pkg::SEL_W-1:0]   theta_reg, theta_next;
    logic                        acc;
    logic                        out_valid_reg;
    logic [RES_W-1:0]            out_data_reg;

    logic [PROD_W-1:0]           prod;
    logic [dcp_pkg::SEL_W-1:0]   entry_sat;
    logic [dcp_pkg::SWEEP_W-1:0] sweep_sum;
    logic [dcp_pkg::SEL_W-1:0]   note_ext;

    assign cmd_take = cmd_valid && (!out_valid_reg || m_tready);
    assign mode     = mode_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dcp_pkg::OUT_DATA_W'(out_data_reg);

    // entry * 10 + digit, saturated
    assign prod = PROD_W'({entry_reg, 3'b000}) + PROD_W'({entry_reg, 1'b0})
                + PROD_W'(cmd.digit);
    assign entry_sat = (prod > PROD_W'(dcp_pkg::ENTRY_MAX)) ?
                       dcp_pkg::ENTRY_MAX : prod[dcp_pkg::SEL_W-1:0];
    assign sweep_sum = sweep_reg + dcp_pkg::SWEEP_W'(SWEEP_STRIDE);
    assign note_ext  = dcp_pkg::SEL_W'(cmd.note);

    always_comb
    begin
        mode_next      = mode_reg;
        entry_next     = entry_reg;
        sweep_next     = sweep_reg;
        led_next       = led_reg;
        led_strip_next = led_strip_reg;
        tri_next       = tri_reg;
        strip_next     = strip_reg;
        phi_next       = phi_reg;
        theta_next     = theta_reg;
        acc            = 1'b1;

        unique case (cmd.op)
            dcp_pkg::OP_KEY:
            begin
                if (mode_reg == dcp_pkg::MODE_INTRO)
                begin
                    acc = 1'b0;
                end
                else if (mode_reg == dcp_pkg::MODE_WAIT)
                begin
                    entry_next = '0;
                    priority if (cmd.is_letter)
                    begin
                        mode_next = cmd.letter_mode;
                    end
                    else if (cmd.is_inc && led_reg != dcp_pkg::SEL_NONE)
                    begin
                        led_next = led_reg + 1'b1;
                    end
                    else if (cmd.is_dec && led_reg != dcp_pkg::SEL_NONE)
                    begin
                        led_next = led_reg - 1'b1;
                    end
                    else
                    begin
                        acc = 1'b0;
                    end
                end
                else
                begin
                    priority if (cmd.is_digit)
                    begin
                        entry_next = entry_sat;
                    end
                    else if (cmd.is_colon && mode_reg == dcp_pkg::MODE_LED)
                    begin
                        led_strip_next = entry_reg;
                        entry_next     = '0;
                    end
                    else if (cmd.is_eol)
                    begin
                        // commit this mode's selection, drop the other led, triangle, strip, phi and theta ones
                        mode_next  = dcp_pkg::MODE_WAIT;
                        led_next   = dcp_pkg::SEL_NONE;
                        tri_next   = dcp_pkg::SEL_NONE;
                        strip_next = dcp_pkg::SEL_NONE;
                        phi_next   = dcp_pkg::SEL_NONE;
                        theta_next = dcp_pkg::SEL_NONE;
                        unique case (mode_reg)
                            dcp_pkg::MODE_LED:      led_next   = entry_reg;
                            dcp_pkg::MODE_TRIANGLE: tri_next   = entry_reg;
                            dcp_pkg::MODE_STRIP:    strip_next = entry_reg;
                            dcp_pkg::MODE_PHI:      phi_next   = entry_reg;
                            default:                theta_next = entry_reg;
                        endcase
                    end
                    else
                    begin
                        acc = 1'b0;
                    end
                end
            end
            dcp_pkg::OP_NOTE_ON:
            begin
                tri_next   = note_ext;
                strip_next = dcp_pkg::SEL_NONE;
                led_next   = dcp_pkg::SEL_NONE;
            end
            dcp_pkg::OP_NOTE_OFF:
            begin
                if (tri_reg == note_ext)
                begin
                    tri_next = dcp_pkg::SEL_NONE;
                end
            end
            default:
            begin
                if (mode_reg == dcp_pkg::MODE_INTRO)
                begin
                    sweep_next = sweep_sum;
                    if (sweep_sum > dcp_pkg::SWEEP_W'(leds_reg))
                    begin
                        mode_next = dcp_pkg::MODE_WAIT;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leds_reg      <= dcp_pkg::LEDS_RESET;
            mode_reg      <= dcp_pkg::MODE_INTRO;
            entry_reg     <= '0;
            sweep_reg     <= '0;
            led_reg       <= dcp_pkg::SEL_NONE;
            led_strip_reg <= '0;
            tri_reg       <= dcp_pkg::SEL_NONE;
            strip_reg     <= dcp_pkg::SEL_NONE;
            phi_reg       <= dcp_pkg::SEL_NONE;
            theta_reg     <= dcp_pkg::SEL_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                leds_reg <= cfg_wdata;
            end
            if (cmd_take)
            begin
                mode_reg      <= mode_next;
                entry_reg     <= entry_next;
                sweep_reg     <= sweep_next;
                led_reg       <= led_next;
                led_strip_reg <= led_strip_next;
                tri_reg       <= tri_next;
                strip_reg     <= strip_next;
                phi_reg       <= phi_next;
                theta_reg     <= theta_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            out_data_reg <= {theta_next, phi_next, strip_next, tri_next,
                             led_strip_next, led_next, mode_next, acc};
        end
    end

endmodule

// ----- design/diagnostic_command_parser.sv -----
// Path: an accepted request waits in the queue and is taken into the result register
// when that register is free or being taken. Throughput: one request per cycle while
// results are taken; the back end retires one queued request each cycle that the
// result register is free or being taken. Reset: asynchronous, active low; clears
// the queue, enters intro mode with no selection lit and sets leds_per_strip to 300.
`include "diagnostic_command_parser_assert.svh"

module diagnostic_command_parser
#(
    parameter int SWEEP_STRIDE = dcp_pkg::SWEEP_STRIDE_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_char [7:0], note_number [14:8], zero [15]
    input  logic [dcp_pkg::IN_DATA_W-1:0]   s_tdata,
    // operation [1:0]
    input  logic [dcp_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted [0], parser_mode [3:1], selected_led [19:4],
    // selected_led_strip [35:20], selected_triangle [51:36],
    // selected_strip [67:52], selected_phi [83:68], selected_theta [99:84],
    // zero [103:100]
    output logic [dcp_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [dcp_pkg::SEL_W-1:0]       cfg_wdata
);

    logic                        push;
    dcp_pkg::cmd_t               push_cmd;
    dcp_pkg::cmd_t               pop_cmd;
    dcp_pkg::q_status_t          q_stat;
    logic                        cmd_take;
    logic [dcp_pkg::MODE_W-1:0]  mode;

    dcp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dcp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (cmd_take),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    dcp_back
    #(
        .SWEEP_STRIDE (SWEEP_STRIDE)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (!q_stat.empty),
        .cmd       (pop_cmd),
        .cmd_take  (cmd_take),
        .mode      (mode),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `DCP_ASSERT_SAME(a_take_needs_entry, cmd_take, !q_stat.empty)
    `DCP_ASSERT_SAME(a_queue_bound, 1'b1, q_stat.count <= dcp_pkg::QCNT_W'(dcp_pkg::QDEPTH))
    `DCP_ASSERT_NEXT(a_event_accepted, cmd_take && pop_cmd.op != dcp_pkg::OP_KEY, m_tdata[0])
    `DCP_ASSERT_NEXT(a_intro_stays_left, mode != dcp_pkg::MODE_INTRO, mode != dcp_pkg::MODE_INTRO)

endmodule

// ----- tb/diagnostic_command_parser_test.sv -----
// Stream testbench for the diagnostic command parser, checked against a local predictor.
`timescale 1ns / 100ps

module diagnostic_command_parser_test;
    import dcp_pkg::*;

    localparam int IDLE_LIMIT     = 1000;
    localparam int PHASE_REQUESTS = 350;
    localparam int PHASES         = 4;

    localparam logic [KEY_W-1:0] ENTRY_LETTERS [5] = '{CH_L, CH_T, CH_S, CH_H, CH_V};
    localparam logic [KEY_W-1:0] STEP_KEYS [4]     = '{CH_PLUS, CH_EQ, CH_MINUS, CH_UNDER};

    typedef struct packed {
        logic              accepted;
        logic [MODE_W-1:0] mode;
        logic [SEL_W-1:0]  led;
        logic [SEL_W-1:0]  led_strip;
        logic [SEL_W-1:0]  triangle;
        logic [SEL_W-1:0]  strip;
        logic [SEL_W-1:0]  phi;
        logic [SEL_W-1:0]  theta;
    } parser_result_t;

    typedef struct {
        logic             is_cfg;
        logic [SEL_W-1:0] cfg_value;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] ch;
        logic [NOTE_W-1:0] note;
        logic             typed;
        parser_result_t   result;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [SEL_W-1:0]      cfg_wdata = '0;

    // predictor state
    logic [SEL_W-1:0]   p_leds;
    logic [MODE_W-1:0]  p_mode;
    logic [SEL_W-1:0]   p_entry;
    logic [SWEEP_W-1:0] p_sweep;
    logic [SEL_W-1:0]   p_led;
    logic [SEL_W-1:0]   p_led_strip;
    logic [SEL_W-1:0]   p_tri;
    logic [SEL_W-1:0]   p_strip;
    logic [SEL_W-1:0]   p_phi;
    logic [SEL_W-1:0]   p_theta;

    parser_result_t expected_results [$];
    stim_row_t      stim_table [$];
    int             mismatches    = 0;
    int             requests_sent = 0;
    int             idle_cycles   = 0;
    bit             steady        = 1'b0;

    diagnostic_command_parser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic parser_result_t advance_parser(input logic [OP_W-1:0] op,
                                                      input logic [KEY_W-1:0] ch,
                                                      input logic [NOTE_W-1:0] note);
        parser_result_t r;
        logic [KEY_W-1:0] up;
        logic ok;
        int unsigned grown;
        ok = 1'b1;
        case (op)
            OP_KEY:
            begin
                if (p_mode == MODE_INTRO)
                    ok = 1'b0;
                else if (p_mode == MODE_WAIT)
                begin
                    p_entry = '0;
                    up = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CH_CASE : ch;
                    case (up)
                        CH_L: p_mode = MODE_LED;
                        CH_T: p_mode = MODE_TRIANGLE;
                        CH_S: p_mode = MODE_STRIP;
                        CH_H: p_mode = MODE_PHI;
                        CH_V: p_mode = MODE_THETA;
                        CH_PLUS, CH_EQ:
                        begin
                            if (p_led == SEL_NONE)
                                ok = 1'b0;
                            else
                                p_led = p_led + 1'b1;
                        end
                        CH_MINUS, CH_UNDER:
                        begin
                            if (p_led == SEL_NONE)
                                ok = 1'b0;
                            else
                                p_led = p_led - 1'b1;
                        end
                        default: ok = 1'b0;
                    endcase
                end
                else if (ch >= CH_ZERO && ch <= CH_NINE)
                begin
                    grown = 10 * p_entry + (ch - CH_ZERO);
                    p_entry = (grown > ENTRY_MAX) ? ENTRY_MAX : grown[SEL_W-1:0];
                end
                else if (p_mode == MODE_LED && (ch == CH_COLON || ch == CH_SEMI))
                begin
                    p_led_strip = p_entry;
                    p_entry = '0;
                end
                else if (ch == CH_CR || ch == CH_LF)
                begin
                    // commit one selection, drop the other led, triangle, strip, phi and theta ones
                    p_led   = SEL_NONE;
                    p_tri   = SEL_NONE;
                    p_strip = SEL_NONE;
                    p_phi   = SEL_NONE;
                    p_theta = SEL_NONE;
                    case (p_mode)
                        MODE_LED:      p_led   = p_entry;
                        MODE_TRIANGLE: p_tri   = p_entry;
                        MODE_STRIP:    p_strip = p_entry;
                        MODE_PHI:      p_phi   = p_entry;
                        default:       p_theta = p_entry;
                    endcase
                    p_mode = MODE_WAIT;
                end
                else
                    ok = 1'b0;
            end
            OP_NOTE_ON:
            begin
                p_tri   = {{(SEL_W-NOTE_W){1'b0}}, note};
                p_strip = SEL_NONE;
                p_led   = SEL_NONE;
            end
            OP_NOTE_OFF:
            begin
                if (p_tri == {{(SEL_W-NOTE_W){1'b0}}, note})
                    p_tri = SEL_NONE;
            end
            default:
            begin
                if (p_mode == MODE_INTRO)
                begin
                    p_sweep = p_sweep + SWEEP_W'(SWEEP_STRIDE_DEF);
                    if (p_sweep > {1'b0, p_leds})
                        p_mode = MODE_WAIT;
                end
            end
        endcase
        r.accepted  = ok;
        r.mode      = p_mode;
        r.led       = p_led;
        r.led_strip = p_led_strip;
        r.triangle  = p_tri;
        r.strip     = p_strip;
        r.phi       = p_phi;
        r.theta     = p_theta;
        return r;
    endfunction

    task automatic push_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] ch,
                                input logic [NOTE_W-1:0] note, input logic typed,
                                input parser_result_t typed_result);
        parser_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, note, ch};
        do @(posedge clk); while (!s_tready);
        predicted = advance_parser(op, ch, note);
        expected_results.push_back(typed ? typed_result : predicted);
        requests_sent++;
    endtask

    task automatic settle_and_write(input logic [SEL_W-1:0] value);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        p_leds = value;
    endtask

    task automatic add_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] ch,
                               input logic [NOTE_W-1:0] note);
        stim_row_t row;
        row = '{is_cfg: 1'b0, cfg_value: '0, op: op, ch: ch, note: note,
                typed: 1'b0, result: '0};
        stim_table.push_back(row);
    endtask

    // rows whose result is all none apart from accepted, mode, triangle and a zero led strip
    task automatic add_checked(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] ch,
                               input logic [NOTE_W-1:0] note, input logic acc,
                               input logic [MODE_W-1:0] mode,
                               input logic [SEL_W-1:0] tri_sel);
        stim_row_t row;
        row = '{is_cfg: 1'b0, cfg_value: '0, op: op, ch: ch, note: note, typed: 1'b1,
                result: '{acc, mode, SEL_NONE, '0, tri_sel, SEL_NONE, SEL_NONE, SEL_NONE}};
        stim_table.push_back(row);
    endtask

    task automatic add_cfg(input logic [SEL_W-1:0] value);
        stim_row_t row;
        row = '{is_cfg: 1'b1, cfg_value: value, op: OP_KEY, ch: '0, note: '0,
                typed: 1'b0, result: '0};
        stim_table.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [SEL_W-1:0] want,
                               input logic [SEL_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge clk)
    begin
        parser_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result arrived with no request pending");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("accepted", want.accepted, m_tdata[0]);
                check_field("parser_mode", want.mode, m_tdata[3:1]);
                check_field("selected_led", want.led, m_tdata[19:4]);
                check_field("selected_led_strip", want.led_strip, m_tdata[35:20]);
                check_field("selected_triangle", want.triangle, m_tdata[51:36]);
                check_field("selected_strip", want.strip, m_tdata[67:52]);
                check_field("selected_phi", want.phi, m_tdata[83:68]);
                check_field("selected_theta", want.theta, m_tdata[99:84]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("diagnostic_command_parser test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [KEY_W-1:0]  letter;
        logic [SEL_W-1:0]  phase_cfg [PHASES];
        int                kind;
        int                count;
        int                phase_start;

        p_leds      = LEDS_RESET;
        p_mode      = MODE_INTRO;
        p_entry     = '0;
        p_sweep     = '0;
        p_led       = SEL_NONE;
        p_led_strip = '0;
        p_tri       = SEL_NONE;
        p_strip     = SEL_NONE;
        p_phi       = SEL_NONE;
        p_theta     = SEL_NONE;

        // intro: keys refused, notes still land, ticks advance the sweep
        add_checked(OP_KEY, CH_L, '0, 1'b0, MODE_INTRO, SEL_NONE);
        add_checked(OP_NOTE_ON, '0, 7'd127, 1'b1, MODE_INTRO, 16'd127);
        add_checked(OP_NOTE_OFF, 8'hFF, 7'd0, 1'b1, MODE_INTRO, 16'd127);
        add_checked(OP_NOTE_OFF, '0, 7'd127, 1'b1, MODE_INTRO, SEL_NONE);
        add_checked(OP_TICK, '0, '0, 1'b1, MODE_INTRO, SEL_NONE);
        add_checked(OP_TICK, 8'hFF, 7'd127, 1'b1, MODE_INTRO, SEL_NONE);
        add_cfg(16'hFFFF);
        add_checked(OP_TICK, '0, '0, 1'b1, MODE_INTRO, SEL_NONE);
        // zero length ends the intro on the next tick
        add_cfg(16'd0);
        add_checked(OP_TICK, '0, '0, 1'b1, MODE_WAIT, SEL_NONE);
        add_checked(OP_TICK, '0, '0, 1'b1, MODE_WAIT, SEL_NONE);
        add_checked(OP_KEY, 8'hFF, '0, 1'b0, MODE_WAIT, SEL_NONE);
        // led entry with strip, saturating digits, step past the top to none, then a theta entry
        add_request(OP_KEY, CH_L + CH_CASE, '0);
        add_request(OP_KEY, CH_ZERO + 8'd1, '0);
        add_request(OP_KEY, CH_SEMI, '0);
        repeat (5) add_request(OP_KEY, CH_NINE, '0);
        add_request(OP_KEY, CH_LF, '0);
        add_request(OP_KEY, CH_PLUS, '0);
        add_request(OP_KEY, CH_PLUS, '0);
        add_request(OP_KEY, CH_V + CH_CASE, '0);
        add_request(OP_KEY, 8'h00, '0);
        add_request(OP_KEY, CH_CR, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
                settle_and_write(stim_table[i].cfg_value);
            else
                push_request(stim_table[i].op, stim_table[i].ch, stim_table[i].note,
                             stim_table[i].typed, stim_table[i].result);
        end

        phase_cfg[0] = 16'd1;
        phase_cfg[1] = 16'(($urandom_range(2, 65534)));
        phase_cfg[2] = 16'hFFFF;
        phase_cfg[3] = LEDS_RESET;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_and_write(phase_cfg[phase]);
            steady = (phase == 2);
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 55)
                begin
                    letter = ENTRY_LETTERS[$urandom_range(0, 4)];
                    if ($urandom_range(0, 1))
                        letter = letter + CH_CASE;
                    push_request(OP_KEY, letter, 7'($urandom_range(0, 127)), 1'b0, '0);
                    if ((letter == CH_L || letter == CH_L + CH_CASE) &&
                        $urandom_range(0, 2) == 0)
                    begin
                        count = $urandom_range(0, 3);
                        repeat (count)
                            push_request(OP_KEY, CH_ZERO + 8'($urandom_range(0, 9)), '0,
                                         1'b0, '0);
                        push_request(OP_KEY, $urandom_range(0, 1) ? CH_COLON : CH_SEMI,
                                     '0, 1'b0, '0);
                    end
                    count = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                         : $urandom_range(0, 4);
                    repeat (count)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            push_request(OP_KEY, 8'($urandom_range(0, 255)), '0, 1'b0, '0);
                        push_request(OP_KEY, CH_ZERO + 8'($urandom_range(0, 9)), '0,
                                     1'b0, '0);
                    end
                    // drop the terminator now and then to leave a broken entry
                    if ($urandom_range(0, 9) != 0)
                        push_request(OP_KEY, $urandom_range(0, 1) ? CH_CR : CH_LF,
                                     7'($urandom_range(0, 127)), 1'b0, '0);
                end
                else if (kind < 67)
                begin
                    repeat ($urandom_range(1, 4))
                        push_request(OP_KEY, STEP_KEYS[$urandom_range(0, 3)], '0, 1'b0, '0);
                end
                else if (kind < 79)
                begin
                    if ($urandom_range(0, 1))
                        push_request(OP_NOTE_ON, 8'($urandom_range(0, 255)),
                                     7'($urandom_range(0, 127)), 1'b0, '0);
                    else
                        push_request(OP_NOTE_OFF, 8'($urandom_range(0, 255)),
                                     $urandom_range(0, 1) ? p_tri[NOTE_W-1:0]
                                                          : 7'($urandom_range(0, 127)),
                                     1'b0, '0);
                end
                else if (kind < 92)
                    push_request(OP_KEY, 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)), 1'b0, '0);
                else
                    push_request(OP_TICK, 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        steady = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("diagnostic_command_parser test passed");
        else
            $display("diagnostic_command_parser test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/dcp_pkg.sv
design/dcp_front.sv
design/dcp_queue.sv
design/dcp_back.sv
design/diagnostic_command_parser.sv
tb/diagnostic_command_parser_test.sv
